// File: sv/lsrc_pkg.sv
package lsrc_pkg;

  // coordinate format, Q12.4 signed
  localparam int COORD_W = 16;
  localparam int FRAC_BITS = 4;
  localparam int SPAN_W = COORD_W - 1;
  // window edges need one more bit: left plus width can pass the coordinate range
  localparam int EDGE_W = COORD_W + 1;
  // magnitudes of differences that the clip loop feeds the divider
  localparam int MAG_W = COORD_W;
  localparam int CNT_W = $clog2(MAG_W);

  localparam int MAX_PASSES = 4;
  localparam int PASS_W = $clog2(MAX_PASSES + 1);

  // apb register map
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SPAN_W-1:0] span_t;
  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [3:0] outcode_t;

  localparam outcode_t OC_LEFT = 4'b0001;
  localparam outcode_t OC_RIGHT = 4'b0010;
  localparam outcode_t OC_BOTTOM = 4'b0100;
  localparam outcode_t OC_TOP = 4'b1000;

  typedef enum logic [1:0] {
    REG_WIN_LEFT = 2'd0,
    REG_WIN_TOP = 2'd1,
    REG_WIN_WIDTH = 2'd2,
    REG_WIN_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CL_IDLE,
    CL_DECIDE,
    CL_WAIT
  } clip_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  // request to the multiply-divide unit: mag_a * mag_b / divisor
  typedef struct packed {
    logic go;
    mag_t mag_a;
    mag_t mag_b;
    mag_t divisor;
  } md_req_t;

  typedef struct packed {
    logic done;
    mag_t quot;
  } md_rsp_t;

  function automatic edge_t edge_add(coord_t base, span_t span);
    edge_add = edge_t'(base) + edge_t'({1'b0, span});
  endfunction

  // region code of one point; points on an edge count as inside
  function automatic outcode_t outcode(coord_t x, coord_t y, coord_t left, coord_t top,
                                       span_t width, span_t height);
    outcode_t c;
    c = '0;
    if (x < left) begin
      c = c | OC_LEFT;
    end else if (edge_t'(x) > edge_add(left, width)) begin
      c = c | OC_RIGHT;
    end
    if (y < top) begin
      c = c | OC_TOP;
    end else if (edge_t'(y) > edge_add(top, height)) begin
      c = c | OC_BOTTOM;
    end
    outcode = c;
  endfunction

endpackage

// File: sv/lsrc_if.sv
interface lsrc_seg_if;
  logic valid;
  logic ready;
  lsrc_pkg::coord_t start_x;
  lsrc_pkg::coord_t start_y;
  lsrc_pkg::coord_t end_x;
  lsrc_pkg::coord_t end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x,
                input end_y, output ready);
endinterface

interface lsrc_res_if;
  logic valid;
  logic ready;
  logic accepted;
  lsrc_pkg::coord_t clip_start_x;
  lsrc_pkg::coord_t clip_start_y;
  lsrc_pkg::coord_t clip_end_x;
  lsrc_pkg::coord_t clip_end_y;

  modport source (output valid, output accepted, output clip_start_x, output clip_start_y,
                  output clip_end_x, output clip_end_y, input ready);
  modport sink (input valid, input accepted, input clip_start_x, input clip_start_y,
                input clip_end_x, input clip_end_y, output ready);
endinterface

// File: sv/lsrc_muldiv.sv
module lsrc_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  lsrc_pkg::md_req_t req,
  output lsrc_pkg::md_rsp_t rsp
);

  lsrc_pkg::md_state_t state;
  lsrc_pkg::md_state_t state_next;
  logic [lsrc_pkg::CNT_W-1:0] count;
  logic last_step;
  logic done;

  // shared product / remainder register: hi:lo
  lsrc_pkg::mag_t hi;
  lsrc_pkg::mag_t lo;
  lsrc_pkg::mag_t mag_a;
  lsrc_pkg::mag_t divisor;

  logic [lsrc_pkg::MAG_W:0] mul_sum;
  logic [lsrc_pkg::MAG_W:0] div_rem;
  logic [lsrc_pkg::MAG_W:0] div_diff;
  logic div_ge;

  assign last_step = (count == lsrc_pkg::CNT_W'(lsrc_pkg::MAG_W - 1));

  // one multiplier bit per cycle, lsb first
  assign mul_sum = {1'b0, hi} + (lo[0] ? {1'b0, mag_a} : '0);

  // one quotient bit per cycle, restoring
  assign div_rem = {hi, lo[lsrc_pkg::MAG_W-1]};
  assign div_diff = div_rem - {1'b0, divisor};
  assign div_ge = (div_rem >= {1'b0, divisor});

  always_comb begin
    state_next = state;
    unique case (state)
      lsrc_pkg::MD_IDLE: begin
        if (req.go) begin
          state_next = lsrc_pkg::MD_MUL;
        end
      end
      lsrc_pkg::MD_MUL: begin
        if (last_step) begin
          state_next = lsrc_pkg::MD_DIV;
        end
      end
      lsrc_pkg::MD_DIV: begin
        if (last_step) begin
          state_next = lsrc_pkg::MD_IDLE;
        end
      end
      default: begin
        state_next = lsrc_pkg::MD_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.done = done;
    // zero divisor gives a zero quotient
    rsp.quot = (divisor == '0) ? '0 : lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsrc_pkg::MD_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == lsrc_pkg::MD_DIV) && last_step;
      if (state == lsrc_pkg::MD_IDLE || last_step) begin
        count <= '0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lsrc_pkg::MD_IDLE: begin
        if (req.go) begin
          hi <= '0;
          lo <= req.mag_b;
          mag_a <= req.mag_a;
          divisor <= req.divisor;
        end
      end
      lsrc_pkg::MD_MUL: begin
        hi <= mul_sum[lsrc_pkg::MAG_W:1];
        lo <= {mul_sum[0], lo[lsrc_pkg::MAG_W-1:1]};
      end
      lsrc_pkg::MD_DIV: begin
        hi <= div_ge ? div_diff[lsrc_pkg::MAG_W-1:0] : div_rem[lsrc_pkg::MAG_W-1:0];
        lo <= {lo[lsrc_pkg::MAG_W-2:0], div_ge};
      end
      default: begin
        hi <= hi;
      end
    endcase
  end

endmodule

// File: sv/line_segment_rect_clipper.sv
// Cohen-Sutherland clipper for one segment per item against the window set over APB
// (win_left, win_top at byte addresses 0, 4 in Q12.4; win_width, win_height at 8, 12 in unsigned Q11.4).
// An item makes P edge moves, 0 to 4, between acceptance and its result. Each
// move takes a decision, a 16-step shift-add multiply and a 16-step restoring
// divide in a bit-serial unit, and a write-back of the moved point. One segment
// is clipped at a time.
// The result sits in an output register, so the next segment is accepted while a
// result waits to be taken.
// Rejected segments (no overlap, or still unresolved after four moves) return
// accepted = 0 with all coordinates zero. Points on a window edge count as inside.
module line_segment_rect_clipper (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lsrc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lsrc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lsrc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  // segments in, clip results out
  lsrc_seg_if.sink                          segment,
  lsrc_res_if.source                        result
);

  // window registers
  lsrc_pkg::coord_t win_left;
  lsrc_pkg::coord_t win_top;
  lsrc_pkg::span_t win_width;
  lsrc_pkg::span_t win_height;
  lsrc_pkg::cfg_reg_t cfg_sel;
  logic cfg_write;

  // working endpoints
  lsrc_pkg::coord_t x0;
  lsrc_pkg::coord_t y0;
  lsrc_pkg::coord_t x1;
  lsrc_pkg::coord_t y1;
  logic [lsrc_pkg::PASS_W-1:0] pass;

  // move in flight
  logic move_end;       // moving the second endpoint
  logic horiz;          // edge is top or bottom: y is fixed, x is solved
  logic neg;
  lsrc_pkg::coord_t edge_val;
  lsrc_pkg::coord_t base;

  lsrc_pkg::clip_state_t state;
  lsrc_pkg::clip_state_t state_next;

  // result register
  logic out_valid;
  logic out_accepted;
  lsrc_pkg::coord_t out_sx;
  lsrc_pkg::coord_t out_sy;
  lsrc_pkg::coord_t out_ex;
  lsrc_pkg::coord_t out_ey;

  lsrc_pkg::md_req_t md_req;
  lsrc_pkg::md_rsp_t md_rsp;

  lsrc_pkg::outcode_t c0;
  lsrc_pkg::outcode_t c1;
  lsrc_pkg::outcode_t co;
  logic accept_now;
  logic reject_now;
  logic resolved;
  logic out_free;
  logic take_in;
  logic load_out;
  logic md_go;

  // setup of one move
  logic co_horiz;
  lsrc_pkg::edge_t co_edge;
  lsrc_pkg::coord_t p0;
  lsrc_pkg::coord_t p1;
  lsrc_pkg::coord_t q0;
  lsrc_pkg::coord_t q1;
  logic signed [lsrc_pkg::EDGE_W-1:0] d_diff;
  logic signed [lsrc_pkg::EDGE_W:0] n_diff;
  logic signed [lsrc_pkg::EDGE_W-1:0] den_diff;
  logic signed [lsrc_pkg::EDGE_W-1:0] d_abs;
  logic signed [lsrc_pkg::EDGE_W:0] n_abs;
  logic signed [lsrc_pkg::EDGE_W-1:0] den_abs;

  // completion of one move
  lsrc_pkg::coord_t q_signed;
  lsrc_pkg::coord_t new_p;
  lsrc_pkg::coord_t new_x;
  lsrc_pkg::coord_t new_y;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_sel = lsrc_pkg::cfg_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_sel)
      lsrc_pkg::REG_WIN_LEFT: prdata = lsrc_pkg::CFG_DATA_W'(win_left);
      lsrc_pkg::REG_WIN_TOP: prdata = lsrc_pkg::CFG_DATA_W'(win_top);
      lsrc_pkg::REG_WIN_WIDTH: prdata = lsrc_pkg::CFG_DATA_W'(win_width);
      lsrc_pkg::REG_WIN_HEIGHT: prdata = lsrc_pkg::CFG_DATA_W'(win_height);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left <= '0;
      win_top <= '0;
      win_width <= '0;
      win_height <= '0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        lsrc_pkg::REG_WIN_LEFT: win_left <= pwdata[lsrc_pkg::COORD_W-1:0];
        lsrc_pkg::REG_WIN_TOP: win_top <= pwdata[lsrc_pkg::COORD_W-1:0];
        lsrc_pkg::REG_WIN_WIDTH: win_width <= pwdata[lsrc_pkg::SPAN_W-1:0];
        lsrc_pkg::REG_WIN_HEIGHT: win_height <= pwdata[lsrc_pkg::SPAN_W-1:0];
        default: win_left <= win_left;
      endcase
    end
  end

  // ---------------------------------------------------------------- decision
  assign c0 = lsrc_pkg::outcode(x0, y0, win_left, win_top, win_width, win_height);
  assign c1 = lsrc_pkg::outcode(x1, y1, win_left, win_top, win_width, win_height);
  assign accept_now = ((c0 | c1) == '0);
  // shared outside bit, or the move budget is spent
  assign reject_now = !accept_now &&
                      (((c0 & c1) != '0) || (pass == lsrc_pkg::PASS_W'(lsrc_pkg::MAX_PASSES)));
  assign resolved = accept_now || reject_now;
  assign out_free = !out_valid || result.ready;

  // first endpoint if outside, else the second
  assign co = (c0 != '0) ? c0 : c1;
  assign co_horiz = ((co & (lsrc_pkg::OC_TOP | lsrc_pkg::OC_BOTTOM)) != '0);

  // edge priority top, bottom, right, left
  always_comb begin
    if ((co & lsrc_pkg::OC_TOP) != '0) begin
      co_edge = lsrc_pkg::edge_t'(win_top);
    end else if ((co & lsrc_pkg::OC_BOTTOM) != '0) begin
      co_edge = lsrc_pkg::edge_add(win_top, win_height);
    end else if ((co & lsrc_pkg::OC_RIGHT) != '0) begin
      co_edge = lsrc_pkg::edge_add(win_left, win_width);
    end else begin
      co_edge = lsrc_pkg::edge_t'(win_left);
    end
  end

  // p is the solved axis, q the axis fixed by the edge;
  // p = p0 + (p1 - p0) * (edge - q0) / (q1 - q0), always from the first endpoint
  assign p0 = co_horiz ? x0 : y0;
  assign p1 = co_horiz ? x1 : y1;
  assign q0 = co_horiz ? y0 : x0;
  assign q1 = co_horiz ? y1 : x1;

  assign d_diff = lsrc_pkg::edge_t'(p1) - lsrc_pkg::edge_t'(p0);
  assign n_diff = (lsrc_pkg::EDGE_W + 1)'(co_edge) - (lsrc_pkg::EDGE_W + 1)'(q0);
  assign den_diff = lsrc_pkg::edge_t'(q1) - lsrc_pkg::edge_t'(q0);

  assign d_abs = d_diff[lsrc_pkg::EDGE_W-1] ? -d_diff : d_diff;
  assign n_abs = n_diff[lsrc_pkg::EDGE_W] ? -n_diff : n_diff;
  assign den_abs = den_diff[lsrc_pkg::EDGE_W-1] ? -den_diff : den_diff;

  // the edge lies between the two q values, so every magnitude fits MAG_W bits
  assign md_req.go = md_go;
  assign md_req.mag_a = d_abs[lsrc_pkg::MAG_W-1:0];
  assign md_req.mag_b = n_abs[lsrc_pkg::MAG_W-1:0];
  assign md_req.divisor = den_abs[lsrc_pkg::MAG_W-1:0];

  lsrc_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // ---------------------------------------------------------------- move result
  assign q_signed = neg ? -lsrc_pkg::coord_t'(md_rsp.quot) : lsrc_pkg::coord_t'(md_rsp.quot);
  assign new_p = base + q_signed;
  assign new_x = horiz ? new_p : edge_val;
  assign new_y = horiz ? edge_val : new_p;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      lsrc_pkg::CL_IDLE: begin
        if (segment.valid) begin
          state_next = lsrc_pkg::CL_DECIDE;
        end
      end
      lsrc_pkg::CL_DECIDE: begin
        if (resolved) begin
          if (out_free) begin
            state_next = lsrc_pkg::CL_IDLE;
          end
        end else begin
          state_next = lsrc_pkg::CL_WAIT;
        end
      end
      lsrc_pkg::CL_WAIT: begin
        if (md_rsp.done) begin
          state_next = lsrc_pkg::CL_DECIDE;
        end
      end
      default: begin
        state_next = lsrc_pkg::CL_IDLE;
      end
    endcase
  end

  always_comb begin
    take_in = 1'b0;
    load_out = 1'b0;
    md_go = 1'b0;
    unique case (state)
      lsrc_pkg::CL_IDLE: begin
        take_in = 1'b1;
      end
      lsrc_pkg::CL_DECIDE: begin
        load_out = resolved && out_free;
        md_go = !resolved;
      end
      lsrc_pkg::CL_WAIT: begin
        md_go = 1'b0;
      end
      default: begin
        take_in = 1'b0;
      end
    endcase
  end

  assign segment.ready = take_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsrc_pkg::CL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working endpoints and move bookkeeping
  always_ff @(posedge clk) begin
    if (take_in && segment.valid) begin
      x0 <= segment.start_x;
      y0 <= segment.start_y;
      x1 <= segment.end_x;
      y1 <= segment.end_y;
      pass <= '0;
    end else if (md_go) begin
      move_end <= (c0 == '0);
      horiz <= co_horiz;
      neg <= d_diff[lsrc_pkg::EDGE_W-1] ^ n_diff[lsrc_pkg::EDGE_W] ^
             den_diff[lsrc_pkg::EDGE_W-1];
      edge_val <= co_edge[lsrc_pkg::COORD_W-1:0];
      base <= p0;
    end else if (state == lsrc_pkg::CL_WAIT && md_rsp.done) begin
      pass <= pass + 1'b1;
      if (move_end) begin
        x1 <= new_x;
        y1 <= new_y;
      end else begin
        x0 <= new_x;
        y0 <= new_y;
      end
    end
  end

  // result payload; rejected segments report zero coordinates
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_accepted <= accept_now;
      out_sx <= accept_now ? x0 : '0;
      out_sy <= accept_now ? y0 : '0;
      out_ex <= accept_now ? x1 : '0;
      out_ey <= accept_now ? y1 : '0;
    end
  end

  assign result.valid = out_valid;
  assign result.accepted = out_accepted;
  assign result.clip_start_x = out_sx;
  assign result.clip_start_y = out_sy;
  assign result.clip_end_x = out_ex;
  assign result.clip_end_y = out_ey;

endmodule
